// ----- rtl/iir_df2_pkg.sv -----
`timescale 1ns / 1ps

package iir_df2_pkg;

    // delay entries are Q9.23, fixed at 32 bits
    localparam int DELAY_W   = 32;
    // a rounded product never needs more than delay width + 3 integer bits + sign
    localparam int RND_W     = DELAY_W + 4;
    // accumulators hold a sample plus up to three rounded products
    localparam int ACC_W     = RND_W + 4;
    localparam int CFG_IDX_W = 3;
    localparam int ORDER_W   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER = 3'd0,
        CFG_FB1   = 3'd1,
        CFG_FB2   = 3'd2,
        CFG_FF0   = 3'd3,
        CFG_FF1   = 3'd4,
        CFG_FF2   = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        A_D0 = 1'b0,
        A_D1 = 1'b1
    } t_a_sel;

    typedef enum logic [2:0] {
        B_FB1 = 3'd0,
        B_FB2 = 3'd1,
        B_FF0 = 3'd2,
        B_FF1 = 3'd3,
        B_FF2 = 3'd4
    } t_b_sel;

    typedef enum logic [1:0] {
        TGT_NONE = 2'd0,
        TGT_V    = 2'd1,
        TGT_Y    = 2'd2
    } t_tgt;

    typedef struct packed {
        logic   load;
        t_a_sel a_sel;
        t_b_sel b_sel;
        t_tgt   tgt;
        logic   commit;
        logic   shift;
        logic   out_load;
    } t_dp_cmd;

endpackage

// ----- rtl/iir_direct_form_two_filter_top.sv -----
// order 2 steps through fb1, ff1, fb2, ff2, satv, ff0, drain and out; order 1 skips fb2 and ff2,
//   order 0 goes straight to satv; one shared multiplier does every
//   product, one per cycle, followed by a round/accumulate cycle
// a finished result sits in an output register so the next sample can be taken meanwhile
// reset (synchronous, active low) clears the delay line, sets order 2, ff0 = 1.0, others 0
`timescale 1ns / 1ps

module iir_direct_form_two_filter_top #(
    parameter int MAX_ORDER   = 2,
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 27
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [iir_df2_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COEF_BITS-1:0]                  i_cfg_data
);
    import iir_df2_pkg::*;

    localparam int NTAPS = (MAX_ORDER > 2) ? 2 : MAX_ORDER;
    localparam int FRAC  = COEF_BITS - 3;

    logic [ORDER_W-1:0]          r_order;
    logic signed [COEF_BITS-1:0] r_fb1, r_fb2, r_ff0, r_ff1, r_ff2;
    logic [ORDER_W-1:0]          w_order_eff;
    t_dp_cmd                     w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_W'(2);
            r_fb1   <= '0;
            r_fb2   <= '0;
            r_ff0   <= {{(COEF_BITS - FRAC - 1){1'b0}}, 1'b1, {FRAC{1'b0}}};
            r_ff1   <= '0;
            r_ff2   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORDER: r_order <= i_cfg_data[ORDER_W-1:0];
                CFG_FB1:   r_fb1   <= i_cfg_data;
                CFG_FB2:   r_fb2   <= i_cfg_data;
                CFG_FF0:   r_ff0   <= i_cfg_data;
                CFG_FF1:   r_ff1   <= i_cfg_data;
                CFG_FF2:   r_ff2   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_order_eff = (r_order > ORDER_W'(NTAPS)) ? ORDER_W'(NTAPS) : r_order;

    iir_df2_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_order     (w_order_eff),
        .o_cmd       (w_cmd)
    );

    iir_df2_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_sample_in  (i_sample_in),
        .i_fb1        (r_fb1),
        .i_fb2        (r_fb2),
        .i_ff0        (r_ff0),
        .i_ff1        (r_ff1),
        .i_ff2        (r_ff2),
        .o_sample_out (o_sample_out)
    );

    // an accepted sample puts the controller to work
    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("controller did not leave idle after input transaction");

    // a new result only appears while a sample was being processed
    a_result_from_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result valid without a sample in flight");

    // the delay line is committed at most once per accepted sample
    a_single_commit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |=> !w_cmd.commit)
        else $error("delay line committed twice in a row");

endmodule

// ----- rtl/iir_df2_ctrl.sv -----
`timescale 1ns / 1ps

module iir_df2_ctrl #(
    parameter int MAX_ORDER = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    input  logic [iir_df2_pkg::ORDER_W-1:0]     i_order,
    output iir_df2_pkg::t_dp_cmd                o_cmd
);
    import iir_df2_pkg::*;

    localparam bit SHIFT_OK = (MAX_ORDER >= 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FB1,
        S_FF1,
        S_FB2,
        S_FF2,
        S_SATV,
        S_FF0,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '{load: 1'b0, a_sel: A_D0, b_sel: B_FF0, tgt: TGT_NONE,
                        commit: 1'b0, shift: 1'b0, out_load: 1'b0};
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_order != '0) ? S_FB1 : S_SATV;
                end
            end
            S_FB1: begin
                o_cmd.a_sel = A_D0;
                o_cmd.b_sel = B_FB1;
                o_cmd.tgt   = TGT_V;
                n_state     = S_FF1;
            end
            S_FF1: begin
                o_cmd.a_sel = A_D0;
                o_cmd.b_sel = B_FF1;
                o_cmd.tgt   = TGT_Y;
                n_state     = (i_order == ORDER_W'(2)) ? S_FB2 : S_SATV;
            end
            S_FB2: begin
                o_cmd.a_sel = A_D1;
                o_cmd.b_sel = B_FB2;
                o_cmd.tgt   = TGT_V;
                n_state     = S_FF2;
            end
            S_FF2: begin
                o_cmd.a_sel = A_D1;
                o_cmd.b_sel = B_FF2;
                o_cmd.tgt   = TGT_Y;
                n_state     = S_SATV;
            end
            S_SATV: begin
                // feedback value is complete: saturate it into the delay line
                o_cmd.commit = 1'b1;
                o_cmd.shift  = SHIFT_OK && (i_order != '0);
                n_state      = S_FF0;
            end
            S_FF0: begin
                // first delay entry now holds the saturated feedback value
                o_cmd.a_sel = A_D0;
                o_cmd.b_sel = B_FF0;
                o_cmd.tgt   = TGT_Y;
                n_state     = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- rtl/iir_df2_datapath.sv -----
`timescale 1ns / 1ps

module iir_df2_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int COEF_BITS   = 27
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iir_df2_pkg::t_dp_cmd          i_cmd,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  logic signed [COEF_BITS-1:0]   i_fb1,
    input  logic signed [COEF_BITS-1:0]   i_fb2,
    input  logic signed [COEF_BITS-1:0]   i_ff0,
    input  logic signed [COEF_BITS-1:0]   i_ff1,
    input  logic signed [COEF_BITS-1:0]   i_ff2,
    output logic signed [SAMPLE_BITS-1:0] o_sample_out
);
    import iir_df2_pkg::*;

    localparam int FRAC   = COEF_BITS - 3;
    localparam int PROD_W = DELAY_W + COEF_BITS;

    logic signed [DELAY_W-1:0]     r_d0, r_d1;
    logic signed [PROD_W-1:0]      r_prod;
    t_tgt                          r_tgt;
    logic signed [ACC_W-1:0]       r_v, r_y;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic signed [DELAY_W-1:0]     w_a;
    logic signed [COEF_BITS-1:0]   w_b;
    logic signed [PROD_W:0]        w_rsum;
    logic signed [RND_W-1:0]       w_rnd;
    logic signed [ACC_W-1:0]       w_rnd_ext;
    logic signed [DELAY_W-1:0]     w_v_sat;
    logic signed [SAMPLE_BITS-1:0] w_y_sat;
    logic                          w_v_ovf, w_y_ovf;

    assign w_a = (i_cmd.a_sel == A_D1) ? r_d1 : r_d0;

    always_comb begin
        case (i_cmd.b_sel)
            B_FB1:   w_b = i_fb1;
            B_FB2:   w_b = i_fb2;
            B_FF0:   w_b = i_ff0;
            B_FF1:   w_b = i_ff1;
            B_FF2:   w_b = i_ff2;
            default: w_b = i_ff0;
        endcase
    end

    // round to nearest, ties up: add half an lsb then floor
    assign w_rsum = {r_prod[PROD_W-1], r_prod}
                  + {{(PROD_W + 1 - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    assign w_rnd     = w_rsum[PROD_W:FRAC];
    assign w_rnd_ext = {{(ACC_W - RND_W){w_rnd[RND_W-1]}}, w_rnd};

    assign w_v_ovf = (r_v[ACC_W-1:DELAY_W-1] != {(ACC_W - DELAY_W + 1){r_v[ACC_W-1]}});
    assign w_v_sat = w_v_ovf ? (r_v[ACC_W-1] ? {1'b1, {(DELAY_W - 1){1'b0}}}
                                             : {1'b0, {(DELAY_W - 1){1'b1}}})
                             : r_v[DELAY_W-1:0];

    assign w_y_ovf = (r_y[ACC_W-1:SAMPLE_BITS-1]
                      != {(ACC_W - SAMPLE_BITS + 1){r_y[ACC_W-1]}});
    assign w_y_sat = w_y_ovf ? (r_y[ACC_W-1] ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
                                             : {1'b0, {(SAMPLE_BITS - 1){1'b1}}})
                             : r_y[SAMPLE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0  <= '0;
            r_d1  <= '0;
            r_tgt <= TGT_NONE;
        end else begin
            r_tgt <= i_cmd.tgt;
            if (i_cmd.commit) begin
                r_d0 <= w_v_sat;
                if (i_cmd.shift) begin
                    r_d1 <= r_d0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        if (i_cmd.load) begin
            r_v <= {{(ACC_W - SAMPLE_BITS){i_sample_in[SAMPLE_BITS-1]}}, i_sample_in};
            r_y <= '0;
        end else begin
            if (r_tgt == TGT_V) begin
                r_v <= r_v - w_rnd_ext;
            end
            if (r_tgt == TGT_Y) begin
                r_y <= r_y + w_rnd_ext;
            end
        end
        if (i_cmd.out_load) begin
            r_out <= w_y_sat;
        end
    end

    assign o_sample_out = r_out;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import iir_df2_pkg::*;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 27;
    localparam int FRAC       = COEF_W - 3;
    localparam int N_PHASES   = 24;
    localparam int PHASE_ITEMS = 75;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE     = 16;

    // indexes past the last register, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    localparam logic [COEF_W-1:0] COEF_MAX  = 27'h3FFFFFF;
    localparam logic [COEF_W-1:0] COEF_MIN  = 27'h4000000;
    localparam logic [COEF_W-1:0] COEF_ONE  = 27'h1000000;
    localparam logic [COEF_W-1:0] COEF_NEG1 = 27'h7000000;
    localparam logic [COEF_W-1:0] COEF_HALF = 27'h0800000;

    localparam logic [SAMPLE_W-1:0] SMP_MAX = 24'h7FFFFF;
    localparam logic [SAMPLE_W-1:0] SMP_MIN = 24'h800000;

    typedef enum logic {
        ROW_CFG    = 1'b0,
        ROW_SAMPLE = 1'b1
    } t_row_kind;

    typedef struct packed {
        t_row_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [COEF_W-1:0]   data;
        logic [SAMPLE_W-1:0] smp;
        logic                fixed_want;
        logic [SAMPLE_W-1:0] want;
    } t_row;

    localparam int DIR_N = 38;

    t_row dir_rows [0:DIR_N-1] = '{
        // pass-through after reset
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b1, SMP_MAX},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MIN,   1'b1, SMP_MIN},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'h0,     1'b1, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'h1,     1'b1, 24'h1},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'hFFFFFF, 1'b1, 24'hFFFFFF},
        // largest gain, output saturates
        '{ROW_CFG,    CFG_FF0,   COEF_MAX, 24'h0, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b1, SMP_MAX},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MIN,   1'b1, SMP_MIN},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'h0,     1'b1, 24'h0},
        // most negative gain flips and saturates
        '{ROW_CFG,    CFG_FF0,   COEF_MIN, 24'h0, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b1, SMP_MIN},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MIN,   1'b1, SMP_MAX},
        // runaway feedback drives the delay line into 32-bit saturation
        '{ROW_CFG,    CFG_FF0,   COEF_ONE, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_FB1,   COEF_MIN, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_FB2,   COEF_MIN, 24'h0, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b0, 24'h0},
        // first order, second taps must have no effect
        '{ROW_CFG,    CFG_ORDER, 27'h0000001, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_FB1,   COEF_HALF, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_FF1,   COEF_MAX, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_FF2,   COEF_MAX, 24'h0, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'h0F4240, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'hD23940, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MAX,   1'b0, 24'h0},
        // order zero, upper data bits set on the order write
        '{ROW_CFG,    CFG_ORDER, 27'h7FFFFFC, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_FF0,   27'h0600000, 24'h0, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'h3D0900, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, SMP_MIN,   1'b0, 24'h0},
        // order three acts as two, spare indexes ignored
        '{ROW_CFG,    CFG_ORDER, 27'h0000003, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_FF2,   COEF_MIN, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_SPARE_A, 27'h5555555, 24'h0, 1'b0, 24'h0},
        '{ROW_CFG,    CFG_SPARE_B, 27'h2AAAAAA, 24'h0, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'h123456, 1'b0, 24'h0},
        '{ROW_SAMPLE, CFG_ORDER, 27'h0, 24'hABCDEF, 1'b0, 24'h0}
    };

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_sample_in = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_sample_out;
    logic                        i_cfg_valid = 1'b0;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [COEF_W-1:0]           i_cfg_data = '0;

    iir_direct_form_two_filter_top #(
        .MAX_ORDER  (2),
        .SAMPLE_BITS(SAMPLE_W),
        .COEF_BITS  (COEF_W)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample_out(o_sample_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter state as the block should hold it
    logic [1:0] cur_order;
    longint     fb_one, fb_two, ff_zero, ff_one, ff_two;
    longint     dly [0:1];

    logic [SAMPLE_W-1:0] filtered_q [$];
    logic [SAMPLE_W-1:0] head_want;

    int  fail_count = 0;
    int  cycle_count = 0;
    int  n_samples = 0;
    int  n_results = 0;
    int  n_cfg = 0;
    int  n_phases = 0;
    int  stall_left = 0;
    bit  calm_phase = 1'b0;

    function automatic longint round_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi, lo;
        hi = (64'sd1 <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic [SAMPLE_W-1:0] filter_sample(logic [SAMPLE_W-1:0] x);
        longint fbv, acc;
        int     taps;
        taps = (cur_order > 2'd2) ? 2 : int'(cur_order);
        fbv  = longint'($signed(x));
        acc  = 0;
        // both taps read the delay line before it shifts
        if (taps >= 1) begin
            fbv -= round_mul(dly[0], fb_one);
            acc += round_mul(dly[0], ff_one);
        end
        if (taps >= 2) begin
            fbv -= round_mul(dly[1], fb_two);
            acc += round_mul(dly[1], ff_two);
        end
        fbv = clamp(fbv, 32);
        if (taps >= 1) dly[1] = dly[0];
        dly[0] = fbv;
        acc += round_mul(fbv, ff_zero);
        acc = clamp(acc, SAMPLE_W);
        return acc[SAMPLE_W-1:0];
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] d);
        longint c;
        c = longint'($signed(d));
        case (idx)
            CFG_ORDER: cur_order = d[1:0];
            CFG_FB1:   fb_one = c;
            CFG_FB2:   fb_two = c;
            CFG_FF0:   ff_zero = c;
            CFG_FF1:   ff_one = c;
            CFG_FF2:   ff_two = c;
            default: ;
        endcase
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COEF_W-1:0] coef_pick(int mode, int span);
        int s;
        int r;
        if (mode < 5) begin
            s = int'($urandom_range(0, 2 * span)) - span;
            return s[COEF_W-1:0];
        end
        if (mode < 8) return COEF_W'($urandom);
        r = $urandom_range(0, 5);
        case (r)
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return '0;
            3: return COEF_ONE;
            4: return COEF_NEG1;
            default: return COEF_HALF;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] sample_pick();
        int r;
        int s;
        r = $urandom_range(0, 99);
        if (r < 70) return SAMPLE_W'($urandom);
        if (r < 85) begin
            case ($urandom_range(0, 4))
                0: return SMP_MAX;
                1: return SMP_MIN;
                2: return '0;
                3: return 24'h1;
                default: return 24'hFFFFFF;
            endcase
        end
        s = int'($urandom_range(0, 2000)) - 1000;
        return s[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        fail_count++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] d);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, d);
        n_cfg++;
    endtask

    // called at a rising edge; leaves valid high after the transaction
    task automatic send_sample(logic [SAMPLE_W-1:0] s, int gap, logic fixed,
                               logic [SAMPLE_W-1:0] want);
        logic [SAMPLE_W-1:0] pred;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        do @(posedge i_clk); while (o_in_stall);
        pred = filter_sample(s);
        filtered_q.push_back(fixed ? want : pred);
        n_samples++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_config();
        int          mode;
        int          r;
        logic [1:0]  ord;
        logic [COEF_W-1:0] d;
        mode = $urandom_range(0, 9);
        r = $urandom_range(0, 9);
        ord = (r < 6) ? 2'd2 : (r < 8) ? 2'd1 : (r < 9) ? 2'd0 : 2'd3;
        d = COEF_W'($urandom);
        d[1:0] = ord;
        cfg_write(CFG_ORDER, d);
        cfg_write(CFG_FB1, coef_pick(mode, 15000000));
        cfg_write(CFG_FB2, coef_pick(mode, 7000000));
        cfg_write(CFG_FF0, coef_pick(mode, 33554432));
        cfg_write(CFG_FF1, coef_pick(mode, 33554432));
        cfg_write(CFG_FF2, coef_pick(mode, 33554432));
        if ($urandom_range(0, 9) < 3)
            cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, COEF_W'($urandom));
        n_phases++;
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, filtered_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check each transaction, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf("unexpected sample_out %06h", o_sample_out));
            end else begin
                head_want = filtered_q.pop_front();
                if (o_sample_out !== head_want)
                    report_mismatch($sformatf("sample_out %06h, expected %06h",
                                              o_sample_out, head_want));
            end
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = idle_len();
        end
    end

    initial begin
        int p;
        int k;
        cur_order = 2'd2;
        fb_one  = 0;
        fb_two  = 0;
        ff_zero = longint'(COEF_ONE);
        ff_one  = 0;
        ff_two  = 0;
        dly[0]  = 0;
        dly[1]  = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                wait_drain();
                cfg_write(dir_rows[r].idx, dir_rows[r].data);
            end else begin
                send_sample(dir_rows[r].smp, idle_len(), dir_rows[r].fixed_want,
                            dir_rows[r].want);
            end
        end
        wait_drain();

        for (p = 0; p < N_PHASES; p++) begin
            calm_phase = (p % 6 == 5);
            random_config();
            for (k = 0; k < PHASE_ITEMS; k++)
                send_sample(sample_pick(), idle_len(), 1'b0, '0);
            wait_drain();
        end

        if (filtered_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));

        $display("covered %0d samples and %0d results over %0d random settings",
                 n_samples, n_results, n_phases);
        $display("%0d register writes, orders zero to three, saturating extremes included",
                 n_cfg);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/iir_df2_pkg.sv
rtl/iir_df2_ctrl.sv
rtl/iir_df2_datapath.sv
rtl/iir_direct_form_two_filter_top.sv
tb/sv/testbench.sv
